>>> rtl/rch_pkg.sv
package rch_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned ProdW  = 23;  // raw count times 100
  localparam int unsigned PctW   = 7;
  localparam int unsigned HueW   = 9;
  localparam int unsigned MagW   = 13; // up to 60 * 100
  localparam int unsigned SnumW  = 14; // up to 100 * 100
  localparam int unsigned SdenW  = 8;
  localparam int unsigned HqW    = 6;  // hue quotient, at most 60

  localparam int unsigned PctSteps = 7;
  localparam int unsigned HsSteps  = 7;
  // input reg, percent divider, min/max stage, hue/sat divider, output reg
  localparam int unsigned NumStages = 1 + 1 + PctSteps + 1 + HsSteps + 1;

  localparam logic [PctW-1:0] PctMax  = 7'd100;
  localparam logic [PctW-1:0] LightHalf = 7'd50;
  localparam logic [SdenW-1:0] SumFull = 8'd200;
  localparam logic [HueW-1:0] HueRed  = 9'd360;
  localparam logic [HueW-1:0] HueGreen = 9'd120;
  localparam logic [HueW-1:0] HueBlue = 9'd240;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // sideband that follows an item through the hue/saturation stages
  typedef struct packed {
    logic            err;
    logic            grey;
    logic [1:0]      sel;
    logic            neg;
    logic [PctW-1:0] light;
  } hs_side_t;

endpackage

>>> rtl/rch_if.sv
interface rch_in_if;
  logic                        valid;
  logic                        ready;
  logic [rch_pkg::RawW-1:0]    red_raw;
  logic [rch_pkg::RawW-1:0]    green_raw;
  logic [rch_pkg::RawW-1:0]    blue_raw;
  logic [rch_pkg::RawW-1:0]    clear_raw;

  modport source (output valid, red_raw, green_raw, blue_raw, clear_raw, input ready);
  modport sink (input valid, red_raw, green_raw, blue_raw, clear_raw, output ready);
endinterface

interface rch_out_if;
  logic                        valid;
  logic                        ready;
  logic [rch_pkg::HueW-1:0]    hue;
  logic [rch_pkg::PctW-1:0]    saturation;
  logic [rch_pkg::PctW-1:0]    lightness;
  logic                        divide_error;

  modport source (output valid, hue, saturation, lightness, divide_error, input ready);
  modport sink (input valid, hue, saturation, lightness, divide_error, output ready);
endinterface

>>> rtl/rch_pct_div.sv
// pipelined restoring divider: num / den, saturated at 100
module rch_pct_div (
  input  logic                          clk_i,
  input  logic [rch_pkg::PctSteps:0]    en_i,
  input  logic [rch_pkg::ProdW-1:0]     num_i,
  input  logic [rch_pkg::RawW-1:0]      den_i,
  output logic [rch_pkg::PctW-1:0]      pct_o
);

  logic [rch_pkg::ProdW-1:0] rem_q [rch_pkg::PctSteps+1];
  logic [rch_pkg::RawW-1:0]  den_q [rch_pkg::PctSteps+1];
  logic [rch_pkg::PctW-1:0]  quo_q [rch_pkg::PctSteps+1];
  logic                      ovf_q [rch_pkg::PctSteps+1];
  logic [rch_pkg::ProdW-1:0] den101;

  // quotient above 100 iff num >= 101 * den
  assign den101 = (rch_pkg::ProdW'(den_i) << 6) + (rch_pkg::ProdW'(den_i) << 5)
                + (rch_pkg::ProdW'(den_i) << 2) + rch_pkg::ProdW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_i >= den101);
    end
  end

  for (genvar s = 1; s <= rch_pkg::PctSteps; s++) begin : g_step
    logic [rch_pkg::ProdW-1:0] dsh;
    logic                      take;
    assign dsh  = rch_pkg::ProdW'(den_q[s-1]) << (rch_pkg::PctSteps - s);
    assign take = (rem_q[s-1] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= take ? (rem_q[s-1] - dsh) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (take ? (rch_pkg::PctW'(1) << (rch_pkg::PctSteps - s))
                                       : '0);
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign pct_o = ovf_q[rch_pkg::PctSteps] ? rch_pkg::PctMax : quo_q[rch_pkg::PctSteps];

endmodule

>>> rtl/raw_color_to_hsl_unit.sv
// a sample passes input, percent divider, min/max, hue/sat divider and output stages
// throughput: one sample per cycle while the output does not stall, set by one
//   restoring-division bit per stage in the percent dividers and in the hue/saturation divider
// stages only hold while the stage after them is full and stalled, so bubbles collapse
// reset: rst_ni is asynchronous active low and clears every stage valid bit;
//   payload registers are not reset
module raw_color_to_hsl_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rch_in_if.sink    sample_i,
  rch_out_if.source result_o
);

  localparam int unsigned NS   = rch_pkg::NumStages;
  localparam int unsigned SM   = 1 + rch_pkg::PctSteps + 1; // min/max stage index
  localparam int unsigned SH0  = SM + 1;                     // first hue/sat step
  localparam int unsigned SOUT = NS - 1;

  // per-stage valid and advance chain
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  assign rdy[NS] = result_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign sample_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= sample_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // input stage: scale each channel by 100 (shift and add)
  logic [rch_pkg::ProdW-1:0] num_r_q, num_g_q, num_b_q;
  logic [rch_pkg::RawW-1:0]  clr_q;

  function automatic logic [rch_pkg::ProdW-1:0] times100(input logic [rch_pkg::RawW-1:0] x);
    logic [rch_pkg::ProdW-1:0] w;
    w = rch_pkg::ProdW'(x);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      num_r_q <= times100(sample_i.red_raw);
      num_g_q <= times100(sample_i.green_raw);
      num_b_q <= times100(sample_i.blue_raw);
      clr_q   <= sample_i.clear_raw;
    end
  end

  // zero clear flag rides alongside the percent dividers
  logic err_q [SM];
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      err_q[0] <= (sample_i.clear_raw == '0);
    end
  end
  for (genvar k = 1; k < SM; k++) begin : g_err
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        err_q[k] <= err_q[k-1];
      end
    end
  end

  // percent of clear per channel
  logic [rch_pkg::PctW-1:0] pct_r, pct_g, pct_b;
  logic [rch_pkg::PctSteps:0] div_en;
  assign div_en = rdy[SM-1:1];

  rch_pct_div u_div_r (.clk_i, .en_i(div_en), .num_i(num_r_q), .den_i(clr_q), .pct_o(pct_r));
  rch_pct_div u_div_g (.clk_i, .en_i(div_en), .num_i(num_g_q), .den_i(clr_q), .pct_o(pct_g));
  rch_pct_div u_div_b (.clk_i, .en_i(div_en), .num_i(num_b_q), .den_i(clr_q), .pct_o(pct_b));

  // min/max stage: pick the dominant channel, hue numerator and saturation operands
  logic [rch_pkg::PctW-1:0]  mx, mn, dif, da, db, absd, light;
  logic [rch_pkg::SdenW-1:0] sum, sden;
  logic [1:0]                sel;
  logic                      neg;
  logic [rch_pkg::MagW-1:0]  mag;
  logic [rch_pkg::SnumW-1:0] snum;

  always_comb begin
    mx = pct_r;
    if (pct_g > mx) mx = pct_g;
    if (pct_b > mx) mx = pct_b;
    mn = pct_r;
    if (pct_g < mn) mn = pct_g;
    if (pct_b < mn) mn = pct_b;
    // ties resolve red, then green, then blue
    if (mx == pct_r) begin
      sel = rch_pkg::SEL_RED;
      da  = pct_g;
      db  = pct_b;
    end else if (mx == pct_g) begin
      sel = rch_pkg::SEL_GREEN;
      da  = pct_b;
      db  = pct_r;
    end else begin
      sel = rch_pkg::SEL_BLUE;
      da  = pct_r;
      db  = pct_g;
    end
    neg   = (da < db);
    absd  = neg ? (db - da) : (da - db);
    mag   = (rch_pkg::MagW'(absd) << 6) - (rch_pkg::MagW'(absd) << 2);
    dif   = mx - mn;
    sum   = rch_pkg::SdenW'(mx) + rch_pkg::SdenW'(mn);
    light = sum[rch_pkg::SdenW-1:1];
    sden  = (light <= rch_pkg::LightHalf) ? sum : (rch_pkg::SumFull - sum);
    snum  = (rch_pkg::SnumW'(dif) << 6) + (rch_pkg::SnumW'(dif) << 5)
          + (rch_pkg::SnumW'(dif) << 2);
  end

  logic [rch_pkg::MagW-1:0]  hrem_q [rch_pkg::HsSteps+1];
  logic [rch_pkg::PctW-1:0]  hden_q [rch_pkg::HsSteps+1];
  logic [rch_pkg::HqW-1:0]   hquo_q [rch_pkg::HsSteps+1];
  logic [rch_pkg::SnumW-1:0] srem_q [rch_pkg::HsSteps+1];
  logic [rch_pkg::SdenW-1:0] sden_q [rch_pkg::HsSteps+1];
  logic [rch_pkg::PctW-1:0]  squo_q [rch_pkg::HsSteps+1];
  rch_pkg::hs_side_t         side_q [rch_pkg::HsSteps+1];

  always_ff @(posedge clk_i) begin
    if (rdy[SM]) begin
      hrem_q[0]       <= mag;
      hden_q[0]       <= dif;
      hquo_q[0]       <= '0;
      srem_q[0]       <= snum;
      sden_q[0]       <= sden;
      squo_q[0]       <= '0;
      side_q[0].err   <= err_q[SM-1];
      side_q[0].grey  <= (dif == '0);
      side_q[0].sel   <= sel;
      side_q[0].neg   <= neg;
      side_q[0].light <= light;
    end
  end

  // one quotient bit per stage; the hue quotient has one bit less and idles last
  for (genvar t = 1; t <= rch_pkg::HsSteps; t++) begin : g_hs
    logic [rch_pkg::MagW-1:0]  hsh;
    logic [rch_pkg::HqW-1:0]   hbit;
    logic [rch_pkg::SnumW-1:0] ssh;
    logic                      htake, stake;

    if (t <= rch_pkg::HqW) begin : g_hue
      assign hsh   = rch_pkg::MagW'(hden_q[t-1]) << (rch_pkg::HqW - t);
      assign hbit  = rch_pkg::HqW'(1) << (rch_pkg::HqW - t);
      assign htake = (hrem_q[t-1] >= hsh);
    end else begin : g_hold
      assign hsh   = '0;
      assign hbit  = '0;
      assign htake = 1'b0;
    end
    assign ssh   = rch_pkg::SnumW'(sden_q[t-1]) << (rch_pkg::HsSteps - t);
    assign stake = (srem_q[t-1] >= ssh);

    always_ff @(posedge clk_i) begin
      if (rdy[SM+t]) begin
        hrem_q[t] <= htake ? (hrem_q[t-1] - hsh) : hrem_q[t-1];
        hden_q[t] <= hden_q[t-1];
        hquo_q[t] <= hquo_q[t-1] | (htake ? hbit : '0);
        srem_q[t] <= stake ? (srem_q[t-1] - ssh) : srem_q[t-1];
        sden_q[t] <= sden_q[t-1];
        squo_q[t] <= squo_q[t-1]
                   | (stake ? (rch_pkg::PctW'(1) << (rch_pkg::HsSteps - t)) : '0);
        side_q[t] <= side_q[t-1];
      end
    end
  end

  // output stage: place the hue around its sector base, clear grey and error cases
  rch_pkg::hs_side_t        fs;
  logic [rch_pkg::HueW-1:0] qh, base, hue_d;
  logic [rch_pkg::HueW-1:0] hue_q;
  logic [rch_pkg::PctW-1:0] sat_q, light_q;
  logic                     err_out_q;

  assign fs = side_q[rch_pkg::HsSteps];
  assign qh = rch_pkg::HueW'(hquo_q[rch_pkg::HsSteps]);

  always_comb begin
    case (fs.sel)
      rch_pkg::SEL_RED:   base = fs.neg ? rch_pkg::HueRed : '0;
      rch_pkg::SEL_GREEN: base = rch_pkg::HueGreen;
      rch_pkg::SEL_BLUE:  base = rch_pkg::HueBlue;
      default:            base = '0;
    endcase
    hue_d = fs.neg ? (base - qh) : (base + qh);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SOUT]) begin
      hue_q     <= (fs.err || fs.grey) ? '0 : hue_d;
      sat_q     <= (fs.err || fs.grey) ? '0 : squo_q[rch_pkg::HsSteps];
      light_q   <= fs.err ? '0 : fs.light;
      err_out_q <= fs.err;
    end
  end

  assign result_o.valid        = vld_q[SOUT];
  assign result_o.hue          = hue_q;
  assign result_o.saturation   = sat_q;
  assign result_o.lightness    = light_q;
  assign result_o.divide_error = err_out_q;

  // the pipeline only refuses input when every stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (&vld_q) && !result_o.ready)
    else $error("input stalled while pipeline has room");

  // an error result carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.divide_error |->
      result_o.hue == '0 && result_o.saturation == '0 && result_o.lightness == '0)
    else $error("error result with nonzero fields");

  // results stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.hue <= rch_pkg::HueRed
      && result_o.saturation <= rch_pkg::PctMax && result_o.lightness <= rch_pkg::PctMax)
    else $error("result field out of range");

  // a stalled output stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=> result_o.valid && $stable(hue_q))
    else $error("stalled result lost");

endmodule

>>> tb/tb_raw_color_to_hsl_unit.sv
`timescale 1ns / 1ps

module tb_raw_color_to_hsl_unit;

  // one hsl result as the block reports it
  typedef struct packed {
    logic [rch_pkg::HueW-1:0] hue;
    logic [rch_pkg::PctW-1:0] sat;
    logic [rch_pkg::PctW-1:0] light;
    logic                     div_err;
  } hsl_t;

  // one row of the directed table; has_gold marks rows whose result is typed in
  typedef struct {
    logic [rch_pkg::RawW-1:0] r, g, b, c;
    bit                       has_gold;
    hsl_t                     gold;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;

  rch_in_if  sample_if ();
  rch_out_if result_if ();

  raw_color_to_hsl_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source)
  );

  hsl_t        hsl_queue[$];
  int          err_count;
  bit          no_idle;      // long stretch with no random idling
  int          hold_off;     // receiver hold-off length, in cycles
  sample_row_t dir_rows[$];

  // 100 mhz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // percent of clear, truncated and clipped at full scale
  function automatic int pct_of(logic [rch_pkg::RawW-1:0] chan, logic [rch_pkg::RawW-1:0] clr);
    longint p;
    p = (longint'(chan) * 100) / longint'(clr);
    return (p > 100) ? 100 : int'(p);
  endfunction

  // integer hsl of one raw sample
  function automatic hsl_t hsl_of(logic [rch_pkg::RawW-1:0] r_raw,
                                  logic [rch_pkg::RawW-1:0] g_raw,
                                  logic [rch_pkg::RawW-1:0] b_raw,
                                  logic [rch_pkg::RawW-1:0] c_raw);
    hsl_t o;
    int r, g, b, mx, mn, dif, sum, h, s, l;
    o = '0;
    if (c_raw == 0) begin
      o.div_err = 1'b1;
      return o;
    end
    r = pct_of(r_raw, c_raw);
    g = pct_of(g_raw, c_raw);
    b = pct_of(b_raw, c_raw);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    l = sum / 2;
    h = 0;
    s = 0;
    if (dif != 0) begin
      // sv int division truncates toward zero, as needed here
      if (mx == r) begin
        h = (60 * (g - b)) / dif;
        if (g < b) h += 360;
      end else if (mx == g) begin
        h = (60 * (b - r)) / dif + 120;
      end else begin
        h = (60 * (r - g)) / dif + 240;
      end
      if (l <= 50) s = (dif * 100) / sum;
      else         s = (dif * 100) / (200 - sum);
    end
    o.hue   = h[rch_pkg::HueW-1:0];
    o.sat   = s[rch_pkg::PctW-1:0];
    o.light = l[rch_pkg::PctW-1:0];
    return o;
  endfunction

  function automatic hsl_t gold_of(int h, int s, int l, bit e);
    hsl_t o;
    o.hue   = h[rch_pkg::HueW-1:0];
    o.sat   = s[rch_pkg::PctW-1:0];
    o.light = l[rch_pkg::PctW-1:0];
    o.div_err = e;
    return o;
  endfunction

  function automatic void add_row(int r, int g, int b, int c, bit has, hsl_t gd);
    sample_row_t row;
    row.r = r[rch_pkg::RawW-1:0];
    row.g = g[rch_pkg::RawW-1:0];
    row.b = b[rch_pkg::RawW-1:0];
    row.c = c[rch_pkg::RawW-1:0];
    row.has_gold = has; row.gold = gd;
    dir_rows.push_back(row);
  endfunction

  // send one sample; the expectation is queued at the transfer edge
  task automatic send_sample(logic [rch_pkg::RawW-1:0] r, logic [rch_pkg::RawW-1:0] g,
                             logic [rch_pkg::RawW-1:0] b, logic [rch_pkg::RawW-1:0] c,
                             bit has, hsl_t gd);
    hsl_t exp_hsl;
    exp_hsl = has ? gd : hsl_of(r, g, b, c);
    if (has && exp_hsl != hsl_of(r, g, b, c)) begin
      $error("table row disagrees with predictor r=%0d g=%0d b=%0d c=%0d", r, g, b, c);
      err_count++;
    end
    // random idle cycles before offering
    while (!no_idle && $urandom_range(99) < 18) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid     <= 1'b1;
    sample_if.red_raw   <= r;
    sample_if.green_raw <= g;
    sample_if.blue_raw  <= b;
    sample_if.clear_raw <= c;
    do @(posedge clk_i); while (!sample_if.ready);
    hsl_queue.push_back(exp_hsl);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    sample_if.valid <= 1'b0;
    @(negedge clk_i);
    while (hsl_queue.size() != 0) @(negedge clk_i);
  endtask

  // random sample: mostly well-scaled counts, sometimes full-range noise
  task automatic send_random();
    logic [rch_pkg::RawW-1:0] r, g, b, c;
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      r = rch_pkg::RawW'($urandom);
      g = rch_pkg::RawW'($urandom);
      b = rch_pkg::RawW'($urandom);
      c = rch_pkg::RawW'($urandom);
    end else if (kind == 1) begin
      c = rch_pkg::RawW'($urandom_range(1, 20));
      r = rch_pkg::RawW'($urandom_range(0, 25));
      g = rch_pkg::RawW'($urandom_range(0, 25));
      b = rch_pkg::RawW'($urandom_range(0, 25));
    end else if (kind == 2) begin
      c = rch_pkg::RawW'($urandom_range(1000, 65535));
      r = rch_pkg::RawW'($urandom_range(0, c));
      g = r;
      b = $urandom_range(0, 1) ? r : rch_pkg::RawW'($urandom_range(0, c));
    end else begin
      c = rch_pkg::RawW'($urandom_range(100, 65535));
      r = rch_pkg::RawW'($urandom_range(0, c));
      g = rch_pkg::RawW'($urandom_range(0, c));
      b = rch_pkg::RawW'($urandom_range(0, c));
      if ($urandom_range(19) == 0) c = '0;
    end
    send_sample(r, g, b, c, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        result_if.ready <= 1'b0;
        hold_off--;
      end else begin
        result_if.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
      end
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    hsl_t exp_hsl;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (hsl_queue.size() == 0) begin
        $error("result with no sample outstanding");
        err_count++;
      end else begin
        exp_hsl = hsl_queue.pop_front();
        if (result_if.hue !== exp_hsl.hue) begin
          $error("hue: expected %0d, actual %0d", exp_hsl.hue, result_if.hue);
          err_count++;
        end
        if (result_if.saturation !== exp_hsl.sat) begin
          $error("saturation: expected %0d, actual %0d", exp_hsl.sat, result_if.saturation);
          err_count++;
        end
        if (result_if.lightness !== exp_hsl.light) begin
          $error("lightness: expected %0d, actual %0d", exp_hsl.light, result_if.lightness);
          err_count++;
        end
        if (result_if.divide_error !== exp_hsl.div_err) begin
          $error("divide_error: expected %0d, actual %0d", exp_hsl.div_err,
                 result_if.divide_error);
          err_count++;
        end
      end
    end
  end

  // hard stop
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int n;
    err_count = 0;
    no_idle   = 1'b0;
    hold_off  = 0;
    rst_ni    = 1'b0;
    sample_if.valid     = 1'b0;
    sample_if.red_raw   = '0;
    sample_if.green_raw = '0;
    sample_if.blue_raw  = '0;
    sample_if.clear_raw = '0;

    // zero clear: error flag, all else zero
    add_row(0, 0, 0, 0, 1, gold_of(0, 0, 0, 1));
    add_row(65535, 65535, 65535, 0, 1, gold_of(0, 0, 0, 1));
    // grey extremes
    add_row(0, 0, 0, 65535, 1, gold_of(0, 0, 0, 0));
    add_row(65535, 65535, 65535, 65535, 1, gold_of(0, 0, 100, 0));
    add_row(65535, 65535, 65535, 1, 1, gold_of(0, 0, 100, 0));  // all clipped
    // pure primaries
    add_row(100, 0, 0, 100, 1, gold_of(0, 100, 50, 0));
    add_row(0, 100, 0, 100, 1, gold_of(120, 100, 50, 0));
    add_row(0, 0, 100, 100, 1, gold_of(240, 100, 50, 0));
    // red largest, green below blue by a hair: quotient truncates to 0, hue 360
    add_row(100, 0, 1, 100, 1, gold_of(360, 100, 50, 0));
    add_row(100, 0, 50, 100, 0, '0);
    // ties for the largest channel
    add_row(100, 100, 0, 100, 1, gold_of(60, 100, 50, 0));
    add_row(0, 100, 100, 100, 1, gold_of(180, 100, 50, 0));
    add_row(100, 0, 100, 100, 1, gold_of(300, 100, 50, 0));
    // high lightness side
    add_row(100, 90, 80, 100, 0, '0);
    add_row(100, 99, 99, 100, 0, '0);
    // low lightness side and small counts, then larger mixed counts
    add_row(1, 0, 0, 100, 0, '0);
    add_row(3, 7, 5, 11, 0, '0);
    add_row(65535, 0, 32768, 65535, 0, '0);
    add_row(12345, 54321, 4660, 40000, 0, '0);
    add_row(21845, 43690, 65535, 65535, 0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].c,
                  dir_rows[i].has_gold, dir_rows[i].gold);

    for (n = 0; n < 400; n++) begin
      if (n == 100) no_idle = 1'b1;           // back-to-back stretch
      if (n == 180) no_idle = 1'b0;
      if (n == 220) hold_off = 60;            // receiver stalls, pipeline fills
      if (n == 300) drain();                  // sender waits for the block to empty
      send_random();
    end

    drain();
    repeat (rch_pkg::NumStages + 4) @(negedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rch_pkg.sv
rtl/rch_if.sv
rtl/rch_pct_div.sv
rtl/raw_color_to_hsl_unit.sv
tb/tb_raw_color_to_hsl_unit.sv
